@@ rtl/lpe_pkg.sv @@
`default_nettype none

package lpe_pkg;

  localparam int unsigned DataWidth  = 32;
  localparam int unsigned CmdWidth   = 2;
  localparam int unsigned IndexWidth = 6;
  localparam int unsigned StatWidth  = 2;
  // wide enough for any length up to the largest capacity and any index
  localparam int unsigned CmpWidth   = 7;

  typedef logic signed [DataWidth-1:0] elem_t;

  localparam logic [CmdWidth-1:0] CmdPushFront = 2'd0;
  localparam logic [CmdWidth-1:0] CmdPushBack  = 2'd1;
  localparam logic [CmdWidth-1:0] CmdDelete    = 2'd2;

  localparam logic [StatWidth-1:0] StatDone  = 2'd0;
  localparam logic [StatWidth-1:0] StatFull  = 2'd1;
  localparam logic [StatWidth-1:0] StatRange = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT,
    CELL_LOAD
  } cell_op_e;

endpackage

`default_nettype wire

@@ rtl/list_push_ends_delete_at_index.sv @@
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells,
// position 0 at the front. A command is taken and updates the row in place;
// the block then dumps the list front to back, one result per cycle while
// the output is free, by rotating the occupied cells through the front
// cell; an empty list still gives one result. A new command is taken once
// the last result of the previous dump sits in the output register. Push
// onto a full list reports status 1 and a delete at an index not below the
// length reports status 2; in both cases the list is left as it was.
module list_push_ends_delete_at_index import lpe_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire  [CmdWidth-1:0]   command_i,
  input  wire  signed [DataWidth-1:0] value_i,
  input  wire  [IndexWidth-1:0] index_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output logic signed [DataWidth-1:0] element_o,
  output logic                  is_last_o,
  output logic                  list_empty_o,
  output logic [StatWidth-1:0]  status_o
);

  localparam int unsigned LenWidth = $clog2(CAPACITY + 1);
  localparam int unsigned CntWidth = $clog2(CAPACITY);

  localparam logic StIdle = 1'b0;
  localparam logic StDump = 1'b1;

  logic                 state_q, state_d;
  logic [LenWidth-1:0]  len_q, len_d;
  logic [CntWidth-1:0]  cnt_q, cnt_d;
  logic [StatWidth-1:0] stat_q, stat_d;

  logic                 out_valid_q, out_valid_d;
  elem_t                element_q, element_d;
  logic                 is_last_q, is_last_d;
  logic                 empty_q, empty_d;
  logic [StatWidth-1:0] ostat_q, ostat_d;

  logic                 accept;
  logic                 dump_step;
  logic                 full;
  logic                 del_ok;
  logic                 last;
  logic [CmpWidth-1:0]  len7;
  logic [CmpWidth-1:0]  idx7;
  elem_t                load_data;

  elem_t    cell_data [CAPACITY];
  cell_op_e cell_op   [CAPACITY];

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign dump_step  = (state_q == StDump) && (!out_valid_q || out_ready_i);
  assign len7       = CmpWidth'(len_q);
  assign idx7       = CmpWidth'(index_i);
  assign full       = (len7 >= CmpWidth'(CAPACITY));
  assign del_ok     = (idx7 < len7);
  assign last       = (len7 == '0) || ((CmpWidth'(cnt_q) + CmpWidth'(1)) == len7);
  assign load_data  = dump_step ? cell_data[0] : value_i;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    elem_t left_nb;
    elem_t right_nb;

    if (i == 0) begin : g_first
      assign left_nb = '0;
    end else begin : g_mid_l
      assign left_nb = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_nb = '0;
    end else begin : g_mid_r
      assign right_nb = cell_data[i+1];
    end

    always_comb begin
      cell_op[i] = CELL_HOLD;
      if (dump_step) begin
        // rotate the occupied cells one place towards the front
        if ((CmpWidth'(i) + CmpWidth'(1)) < len7) begin
          cell_op[i] = CELL_FROM_RIGHT;
        end else if ((CmpWidth'(i) + CmpWidth'(1)) == len7) begin
          cell_op[i] = CELL_LOAD;
        end
      end else if (accept) begin
        case (command_i)
          CmdPushFront: begin
            if (!full) begin
              cell_op[i] = (i == 0) ? CELL_LOAD : CELL_FROM_LEFT;
            end
          end
          CmdPushBack: begin
            if (!full && (CmpWidth'(i) == len7)) begin
              cell_op[i] = CELL_LOAD;
            end
          end
          default: begin
            if (del_ok && (CmpWidth'(i) >= idx7) && (i < CAPACITY - 1)) begin
              cell_op[i] = CELL_FROM_RIGHT;
            end
          end
        endcase
      end
    end

    lpe_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op[i]),
      .left_i  (left_nb),
      .right_i (right_nb),
      .load_i  (load_data),
      .data_o  (cell_data[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q;
    element_d   = element_q;
    is_last_d   = is_last_q;
    empty_d     = empty_q;
    ostat_d     = ostat_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (accept) begin
      state_d = StDump;
      cnt_d   = '0;
      stat_d  = StatDone;
      case (command_i)
        CmdPushFront, CmdPushBack: begin
          if (full) begin
            stat_d = StatFull;
          end else begin
            len_d = len_q + LenWidth'(1);
          end
        end
        default: begin
          if (del_ok) begin
            len_d = len_q - LenWidth'(1);
          end else begin
            stat_d = StatRange;
          end
        end
      endcase
    end

    if (dump_step) begin
      out_valid_d = 1'b1;
      element_d   = (len7 == '0) ? elem_t'(0) : cell_data[0];
      is_last_d   = last;
      empty_d     = (len7 == '0);
      ostat_d     = stat_q;
      cnt_d       = cnt_q + CntWidth'(1);
      if (last) begin
        state_d = StIdle;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      len_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stat_q    <= stat_d;
    element_q <= element_d;
    is_last_q <= is_last_d;
    empty_q   <= empty_d;
    ostat_q   <= ostat_d;
  end

  assign out_valid_o  = out_valid_q;
  assign element_o    = element_q;
  assign is_last_o    = is_last_q;
  assign list_empty_o = empty_q;
  assign status_o     = ostat_q;

endmodule

`default_nettype wire

@@ rtl/lpe_cell.sv @@
`default_nettype none

module lpe_cell import lpe_pkg::*; (
  input  wire      clk_i,
  input  cell_op_e op_i,
  input  elem_t    left_i,
  input  elem_t    right_i,
  input  elem_t    load_i,
  output elem_t    data_o
);

  elem_t data_q;
  elem_t data_d;

  always_comb begin
    case (op_i)
      CELL_FROM_LEFT:  data_d = left_i;
      CELL_FROM_RIGHT: data_d = right_i;
      CELL_LOAD:       data_d = load_i;
      default:         data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire
